// ----- rtl/gnos_pkg.sv -----
// gnos_pkg: shared types, constants and the permutation table of the
// octave-summed gradient noise block. depends on nothing.
package gnos_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COORD_W = 24;
  localparam int AMP_W   = 17;
  localparam int OUT_W   = 16;
  localparam int CIDX_W  = 4;
  localparam int CDATA_W = 17;

  typedef enum logic [CIDX_W-1:0] {
    CFG_OCTAVE_COUNT = 4'd0,
    CFG_PERSISTENCE  = 4'd1,
    CFG_FREQ_MULT    = 4'd2,
    CFG_NORM_RECIP   = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  octave_count;
    logic [15:0] persistence;
    logic [15:0] freq_mult;
    logic [16:0] norm_recip;
  } cfg_t;

  localparam logic [7:0] PERM_TABLE [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    return PERM_TABLE[idx];
  endfunction

endpackage

// ----- rtl/gradient_noise_3d_octave_sum.sv -----
// gradient_noise_3d_octave_sum: fractal sum of 3d gradient noise, one point
// per clock through a chain of octave cells. depends on gnos_pkg, gnos_cell.
//
// usage:
//  - slave stream carries one point per item: x, y, z in unsigned q8.16,
//    wrapping at 256; master stream returns one q1.15 noise value per item
//  - octave count, persistence, frequency multiplier and output scale are
//    written through the plain write port while the block is idle
//  - throughput: one item per cycle while the receiver does not stall
//  - path: the accepting edge loads the input register, then each cell is
//    a 13-stage pipe, then come the split final multiply and the output
//    register, which drives output valid
//  - every cell is always in the path; cells past the configured octave
//    count pass the sum through untouched
//  - when the receiver stalls with a result held in the output register,
//    the whole pipe freezes and s_axis_tready drops; the held item and
//    everything in flight are kept
//  - reset empties the pipe and loads the register defaults: one octave,
//    persistence one half, frequency doubling, unit output scale
module gradient_noise_3d_octave_sum import gnos_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [71:0]         s_axis_tdata,   // coord_x, coord_y, coord_z
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // noise_value
  input  logic                cfg_we_i,
  input  logic [CIDX_W-1:0]   cfg_idx_i,
  input  logic [CDATA_W-1:0]  cfg_data_i
);

  localparam int F     = FRAC_BITS;
  localparam int SW    = F + 25;
  localparam int HW    = SW - 24;
  localparam int FULLW = SW + 18;
  localparam logic signed [FULLW-1:0] RndC = FULLW'(1) <<< (F + 16);
  localparam logic signed [FULLW-1:0] MaxC = FULLW'(32767);
  localparam logic signed [FULLW-1:0] MinC = -FULLW'(32768);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_count <= 4'd1;
      cfg_q.persistence  <= 16'd32768;
      cfg_q.freq_mult    <= 16'd512;
      cfg_q.norm_recip   <= 17'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OCTAVE_COUNT: cfg_q.octave_count <= cfg_data_i[3:0];
        CFG_PERSISTENCE:  cfg_q.persistence  <= cfg_data_i[15:0];
        CFG_FREQ_MULT:    cfg_q.freq_mult    <= cfg_data_i[15:0];
        CFG_NORM_RECIP:   cfg_q.norm_recip   <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // whole pipe moves unless a finished item is stuck at the output
  logic en;
  logic out_v_q;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // input register
  logic               in_v_q;
  logic [COORD_W-1:0] in_c_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else if (en) in_v_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_c_q[0] <= s_axis_tdata[23:0];
      in_c_q[1] <= s_axis_tdata[47:24];
      in_c_q[2] <= s_axis_tdata[71:48];
    end
  end

  // chain of octave cells: each hands the scaled point, the next amplitude
  // and the partial sum to its neighbor
  logic                 ch_v   [MAX_OCTAVES+1];
  logic signed [SW-1:0] ch_sum [MAX_OCTAVES+1];
  logic [AMP_W-1:0]     ch_amp [MAX_OCTAVES+1];
  logic [COORD_W-1:0]   ch_c   [MAX_OCTAVES+1][3];

  assign ch_v[0]   = in_v_q;
  assign ch_sum[0] = '0;
  assign ch_amp[0] = AMP_W'(65536);
  assign ch_c[0]   = in_c_q;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    gnos_cell #(
      .FRAC_BITS (FRAC_BITS),
      .IDX       (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .cfg_i       (cfg_q),
      .in_valid_i  (ch_v[k]),
      .in_sum_i    (ch_sum[k]),
      .in_amp_i    (ch_amp[k]),
      .in_coord_i  (ch_c[k]),
      .out_valid_o (ch_v[k+1]),
      .out_sum_o   (ch_sum[k+1]),
      .out_amp_o   (ch_amp[k+1]),
      .out_coord_o (ch_c[k+1])
    );
  end

  // output scale, split into low and high partial products
  logic                      fv_q;
  logic [40:0]               lo_p_q;
  logic signed [HW+17:0]     hi_p_q;
  logic signed [FULLW-1:0]   full, rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      fv_q    <= ch_v[MAX_OCTAVES];
      out_v_q <= fv_q;
    end
  end

  always_comb begin
    full = (FULLW'(hi_p_q) <<< 24) + FULLW'($signed({1'b0, lo_p_q}));
    rnd  = (full + RndC) >>> (F + 17);
  end

  logic [OUT_W-1:0] out_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_p_q <= {17'b0, ch_sum[MAX_OCTAVES][23:0]} * {24'b0, cfg_q.norm_recip};
      hi_p_q <= (HW+18)'($signed(ch_sum[MAX_OCTAVES][SW-1:24]))
              * (HW+18)'($signed({1'b0, cfg_q.norm_recip}));
      // round half up, then saturate to q1.15
      if (rnd > MaxC) out_d_q <= 16'h7fff;
      else if (rnd < MinC) out_d_q <= 16'h8000;
      else out_d_q <= rnd[OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;

endmodule

// ----- rtl/gnos_cell.sv -----
// gnos_cell: one octave of gradient noise as a 13-stage pipeline; adds its
// weighted value to the running sum and hands the scaled point onward.
// depends on gnos_pkg.
module gnos_cell import gnos_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  cfg_t                       cfg_i,
  input  logic                       in_valid_i,
  input  logic signed [FRAC_BITS+24:0] in_sum_i,
  input  logic [AMP_W-1:0]           in_amp_i,
  input  logic [COORD_W-1:0]         in_coord_i [3],
  output logic                       out_valid_o,
  output logic signed [FRAC_BITS+24:0] out_sum_o,
  output logic [AMP_W-1:0]           out_amp_o,
  output logic [COORD_W-1:0]         out_coord_o [3]
);

  localparam int F   = FRAC_BITS;
  localparam int L   = 13;
  localparam int VW  = F + 3;
  localparam int DW  = VW + 1;
  localparam int PW  = F + 2 + DW;
  localparam int SW  = F + 25;
  localparam int TMW = VW + 18;
  localparam int FSW = F + 6;
  localparam logic signed [VW-1:0]  OneV  = VW'(1) <<< F;
  localparam logic signed [FSW-1:0] OneF  = FSW'(1) <<< F;
  localparam logic [4:0]            IdxC  = 5'(IDX);

  function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
                                                input logic signed [VW-1:0] x,
                                                input logic signed [VW-1:0] y,
                                                input logic signed [VW-1:0] z);
    logic signed [VW-1:0] gu, gv;
    gu = (h < 4'd8) ? x : y;
    if (h < 4'd4) gv = y;
    else if (h == 4'd12 || h == 4'd14) gv = x;
    else gv = z;
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  // side band carried along the pipe
  logic               pv_q [1:L];
  logic               pact_q [1:L];
  logic signed [SW-1:0] ps_q [1:L];
  logic [AMP_W-1:0]   pa_q [1:L];
  logic [AMP_W-1:0]   pn_q [1:L];
  logic [COORD_W-1:0] pc_q [1:L][3];

  logic               act_d;
  logic [AMP_W-1:0]   ampn_d;
  logic [COORD_W-1:0] nc_d [3];
  logic [2*F-1:0]     m2 [3];
  logic [F+15:0]      fx [3];
  logic [39:0]        mc [3];
  logic [32:0]        ma;

  // stage registers
  logic [F-1:0] t1_d [3], t1_q [3], t21_d [3], t21_q [3];
  logic [7:0]   ip1_d [3], ip1_q [3], px0_d, px0_q, px1_d, px1_q;
  logic [F-1:0] t2_d [3], t2_q [3], t32_d [3], t32_q [3];
  logic [7:0]   aa_d, aa_q, ab_d, ab_q, ba_d, ba_q, bb_d, bb_q;
  logic [7:0]   ha, hb;
  logic [F-1:0] t3_d [3], t3_q [3], t33_d [3], t33_q [3], t43_d [3], t43_q [3];
  logic [3:0]   h3_d [8], h3_q [8];
  logic [F-1:0] t34_d [3], t34_q [3], t44_d [3], t44_q [3], t54_d [3], t54_q [3];
  logic signed [VW-1:0] g4_d [8], g4_q [8];
  logic signed [VW-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [FSW-1:0] fs [3];
  logic [F:0]   f5_d [3], f5_q [3], f6_q [3], f7_q [3], f8_q [3], f9_q [3];
  logic signed [VW-1:0] ga5_d [4], ga5_q [4], ga6_q [4];
  logic signed [DW-1:0] dx5_d [4], dx5_q [4];
  logic signed [PW-1:0] px6_d [4], px6_q [4];
  logic signed [VW-1:0] lx [4];
  logic signed [VW-1:0] ya7_d [2], ya7_q [2], ya8_q [2];
  logic signed [DW-1:0] dy7_d [2], dy7_q [2];
  logic signed [PW-1:0] py8_d [2], py8_q [2];
  logic signed [VW-1:0] ly [2];
  logic signed [VW-1:0] za9_d, za9_q, za10_q;
  logic signed [DW-1:0] dz9_d, dz9_q;
  logic signed [PW-1:0] pz10_d, pz10_q;
  logic signed [VW-1:0] n11_d, n11_q;
  logic signed [TMW-1:0] tm12_d, tm12_q;
  logic signed [SW-1:0] sum13_d;

  // stage 1: split point, t squared, first hash level, next octave point
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fx[a]    = {in_coord_i[a][15:0], {F{1'b0}}};
      t1_d[a]  = fx[a][F+15:16];
      ip1_d[a] = in_coord_i[a][23:16];
      m2[a]    = (2*F)'(t1_d[a]) * (2*F)'(t1_d[a]);
      t21_d[a] = m2[a][2*F-1:F];
      mc[a]    = {16'b0, in_coord_i[a]} * {24'b0, cfg_i.freq_mult};
      nc_d[a]  = mc[a][31:8];
    end
    px0_d  = perm_lookup(ip1_d[0]);
    px1_d  = perm_lookup(ip1_d[0] + 8'd1);
    ma     = {16'b0, in_amp_i} * {17'b0, cfg_i.persistence};
    ampn_d = ma[32:16];
    act_d  = {1'b0, cfg_i.octave_count} > IdxC;
  end

  // stage 2: t cubed, corner hashes of the rows
  always_comb begin
    logic [2*F-1:0] m;
    for (int a = 0; a < 3; a++) begin
      m        = (2*F)'(t21_q[a]) * (2*F)'(t1_q[a]);
      t32_d[a] = m[2*F-1:F];
      t2_d[a]  = t1_q[a];
    end
    ha   = px0_q + ip1_q[1];
    hb   = px1_q + ip1_q[1];
    aa_d = perm_lookup(ha) + ip1_q[2];
    ab_d = perm_lookup(ha + 8'd1) + ip1_q[2];
    ba_d = perm_lookup(hb) + ip1_q[2];
    bb_d = perm_lookup(hb + 8'd1) + ip1_q[2];
  end

  // stage 3: t^4, gradient selectors of the eight corners
  always_comb begin
    logic [2*F-1:0] m;
    for (int a = 0; a < 3; a++) begin
      m        = (2*F)'(t32_q[a]) * (2*F)'(t2_q[a]);
      t43_d[a] = m[2*F-1:F];
      t33_d[a] = t32_q[a];
      t3_d[a]  = t2_q[a];
    end
    h3_d[0] = 4'(perm_lookup(aa_q));
    h3_d[1] = 4'(perm_lookup(ba_q));
    h3_d[2] = 4'(perm_lookup(ab_q));
    h3_d[3] = 4'(perm_lookup(bb_q));
    h3_d[4] = 4'(perm_lookup(aa_q + 8'd1));
    h3_d[5] = 4'(perm_lookup(ba_q + 8'd1));
    h3_d[6] = 4'(perm_lookup(ab_q + 8'd1));
    h3_d[7] = 4'(perm_lookup(bb_q + 8'd1));
  end

  // stage 4: t^5, corner dot products
  always_comb begin
    logic [2*F-1:0] m;
    for (int a = 0; a < 3; a++) begin
      m        = (2*F)'(t43_q[a]) * (2*F)'(t3_q[a]);
      t54_d[a] = m[2*F-1:F];
      t44_d[a] = t43_q[a];
      t34_d[a] = t33_q[a];
    end
    x0 = $signed({3'b0, t3_q[0]});
    y0 = $signed({3'b0, t3_q[1]});
    z0 = $signed({3'b0, t3_q[2]});
    x1 = x0 - OneV;
    y1 = y0 - OneV;
    z1 = z0 - OneV;
    g4_d[0] = grad(h3_q[0], x0, y0, z0);
    g4_d[1] = grad(h3_q[1], x1, y0, z0);
    g4_d[2] = grad(h3_q[2], x0, y1, z0);
    g4_d[3] = grad(h3_q[3], x1, y1, z0);
    g4_d[4] = grad(h3_q[4], x0, y0, z1);
    g4_d[5] = grad(h3_q[5], x1, y0, z1);
    g4_d[6] = grad(h3_q[6], x0, y1, z1);
    g4_d[7] = grad(h3_q[7], x1, y1, z1);
  end

  // stage 5: fade curves, x differences
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fs[a] = $signed({6'b0, t54_q[a]}) * FSW'(6) - $signed({6'b0, t44_q[a]}) * FSW'(15)
            + $signed({6'b0, t34_q[a]}) * FSW'(10);
      if (fs[a] < 0) f5_d[a] = '0;
      else if (fs[a] > OneF) f5_d[a] = (F+1)'(OneF);
      else f5_d[a] = fs[a][F:0];
    end
    for (int k = 0; k < 4; k++) begin
      ga5_d[k] = g4_q[2*k];
      dx5_d[k] = DW'(g4_q[2*k+1]) - DW'(g4_q[2*k]);
    end
  end

  // stages 6 to 11: trilinear blend
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px6_d[k] = PW'($signed({1'b0, f5_q[0]})) * PW'(dx5_q[k]);
      lx[k]    = ga6_q[k] + VW'(px6_q[k] >>> F);
    end
    ya7_d[0] = lx[0];
    ya7_d[1] = lx[2];
    dy7_d[0] = DW'(lx[1]) - DW'(lx[0]);
    dy7_d[1] = DW'(lx[3]) - DW'(lx[2]);
    for (int j = 0; j < 2; j++) begin
      py8_d[j] = PW'($signed({1'b0, f7_q[1]})) * PW'(dy7_q[j]);
      ly[j]    = ya8_q[j] + VW'(py8_q[j] >>> F);
    end
    za9_d  = ly[0];
    dz9_d  = DW'(ly[1]) - DW'(ly[0]);
    pz10_d = PW'($signed({1'b0, f9_q[2]})) * PW'(dz9_q);
    n11_d  = za10_q + VW'(pz10_q >>> F);
    // stage 12/13: weight by amplitude and accumulate
    tm12_d  = pact_q[11] ? TMW'($signed({1'b0, pa_q[11]})) * TMW'(n11_q) : '0;
    sum13_d = ps_q[12] + SW'(tm12_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= L; s++) pv_q[s] <= 1'b0;
    end else if (en_i) begin
      pv_q[1] <= in_valid_i;
      for (int s = 2; s <= L; s++) pv_q[s] <= pv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pact_q[1] <= act_d;
      ps_q[1]   <= in_sum_i;
      pa_q[1]   <= in_amp_i;
      pn_q[1]   <= ampn_d;
      pc_q[1]   <= nc_d;
      for (int s = 2; s <= L; s++) begin
        pact_q[s] <= pact_q[s-1];
        pa_q[s]   <= pa_q[s-1];
        pn_q[s]   <= pn_q[s-1];
        pc_q[s]   <= pc_q[s-1];
        if (s != L) ps_q[s] <= ps_q[s-1];
      end
      ps_q[L] <= sum13_d;
      t1_q  <= t1_d;  t21_q <= t21_d; ip1_q <= ip1_d; px0_q <= px0_d; px1_q <= px1_d;
      t2_q  <= t2_d;  t32_q <= t32_d;
      aa_q  <= aa_d;  ab_q  <= ab_d;  ba_q  <= ba_d;  bb_q  <= bb_d;
      t3_q  <= t3_d;  t33_q <= t33_d; t43_q <= t43_d; h3_q  <= h3_d;
      t34_q <= t34_d; t44_q <= t44_d; t54_q <= t54_d; g4_q  <= g4_d;
      f5_q  <= f5_d;  ga5_q <= ga5_d; dx5_q <= dx5_d;
      f6_q  <= f5_q;  ga6_q <= ga5_q; px6_q <= px6_d;
      f7_q  <= f6_q;  ya7_q <= ya7_d; dy7_q <= dy7_d;
      f8_q  <= f7_q;  ya8_q <= ya7_q; py8_q <= py8_d;
      f9_q  <= f8_q;  za9_q <= za9_d; dz9_q <= dz9_d;
      za10_q <= za9_q; pz10_q <= pz10_d;
      n11_q  <= n11_d;
      tm12_q <= tm12_d;
    end
  end

  assign out_valid_o = pv_q[L];
  assign out_sum_o   = ps_q[L];
  assign out_amp_o   = pn_q[L];
  assign out_coord_o = pc_q[L];

endmodule

// ----- test/gnos_checker.sv -----
// gnos_checker: watches both streams and the write port of the noise block,
// predicts every noise value and compares. depends on gnos_pkg.
`timescale 1ns / 100ps

module gnos_checker import gnos_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [71:0]        s_data_i,
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [15:0]        m_data_i,
  input  logic               cfg_we_i,
  input  logic [CIDX_W-1:0]  cfg_idx_i,
  input  logic [CDATA_W-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int FB = 16;

  logic [3:0]  octaves;
  logic [15:0] persist;
  logic [15:0] fmul;
  logic [16:0] nrecip;
  logic signed [15:0] noise_q[$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint fade(longint t);
    longint t2, t3, t4, t5, f;
    t2 = fshift(t * t, FB);
    t3 = fshift(t2 * t, FB);
    t4 = fshift(t3 * t, FB);
    t5 = fshift(t4 * t, FB);
    f = 6 * t5 - 15 * t4 + 10 * t3;
    if (f < 0) f = 0;
    if (f > (64'sd1 << FB)) f = 64'sd1 << FB;
    return f;
  endfunction

  function automatic longint lerp(longint t, longint a, longint b);
    return a + fshift(t * (b - a), FB);
  endfunction

  function automatic longint grad(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] pt(int i);
    return PERM_TABLE[i & 255];
  endfunction

  function automatic longint lattice_noise(logic [23:0] cx, logic [23:0] cy,
                                           logic [23:0] cz);
    longint x, y, z, x1, y1, z1, u, v, w, n0, n1;
    int xi, yi, zi, a, aa, ab, b, ba, bb;
    xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
    x = cx[15:0]; y = cy[15:0]; z = cz[15:0];
    u = fade(x); v = fade(y); w = fade(z);
    a = pt(xi) + yi; aa = pt(a) + zi; ab = pt(a + 1) + zi;
    b = pt(xi + 1) + yi; ba = pt(b) + zi; bb = pt(b + 1) + zi;
    x1 = x - (64'sd1 << FB); y1 = y - (64'sd1 << FB); z1 = z - (64'sd1 << FB);
    n0 = lerp(v, lerp(u, grad(pt(aa), x, y, z), grad(pt(ba), x1, y, z)),
                 lerp(u, grad(pt(ab), x, y1, z), grad(pt(bb), x1, y1, z)));
    n1 = lerp(v, lerp(u, grad(pt(aa + 1), x, y, z1), grad(pt(ba + 1), x1, y, z1)),
                 lerp(u, grad(pt(ab + 1), x, y1, z1), grad(pt(bb + 1), x1, y1, z1)));
    return lerp(w, n0, n1);
  endfunction

  function automatic logic signed [15:0] octave_sum(logic [71:0] pnt);
    logic [23:0] cx, cy, cz;
    longint amp, total, r;
    int n;
    cx = pnt[23:0]; cy = pnt[47:24]; cz = pnt[71:48];
    n = (octaves > 8) ? 8 : octaves;
    amp = 65536; total = 0;
    for (int i = 0; i < n; i++) begin
      total += amp * lattice_noise(cx, cy, cz);
      amp = (amp * persist) >> 16;
      cx = 24'((64'(cx) * fmul) >> 8);
      cy = 24'((64'(cy) * fmul) >> 8);
      cz = 24'((64'(cz) * fmul) >> 8);
    end
    r = fshift(total * longint'(nrecip) + (64'sd1 << (FB + 16)), FB + 17);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  assign pending_o = noise_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      octaves <= 4'd1; persist <= 16'd32768; fmul <= 16'd512; nrecip <= 17'd65536;
      noise_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_OCTAVE_COUNT: octaves <= cfg_data_i[3:0];
          CFG_PERSISTENCE:  persist <= cfg_data_i[15:0];
          CFG_FREQ_MULT:    fmul    <= cfg_data_i[15:0];
          CFG_NORM_RECIP:   nrecip  <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) noise_q.push_back(octave_sum(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (noise_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected item, noise %0d", $signed(m_data_i));
        end else begin
          want = noise_q.pop_front();
          if (want !== $signed(m_data_i)) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("noise_value: expected %0d got %0d", want, $signed(m_data_i));
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_top.sv -----
// tb_top: stimulus and verdict for the octave-summed gradient noise block.
// depends on gnos_pkg, gnos_checker and the block itself.
`timescale 1ns / 100ps

module tb_top;
  import gnos_pkg::*;

  // pipe depth with max octaves, used for drain waits
  localparam int LATENCY = 13 * 8 + 3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [71:0]        s_data = '0;    // coord_x, coord_y, coord_z
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [15:0]        m_data;         // noise_value
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_idx = '0;
  logic [CDATA_W-1:0] cfg_data = '0;
  int                 fail_count;
  int                 pending;

  // idling knobs; busy_mode is shared by both sides
  bit                 busy_mode = 1'b0;  // no idling while high
  bit                 hold_off = 1'b0;   // receiver blocks a long stretch

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  gradient_noise_3d_octave_sum uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  gnos_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) m_ready <= 1'b0;
    else if (busy_mode) m_ready <= 1'b1;
    else m_ready <= ($urandom_range(0, 99) >= 30);
  end

  // one point offered until the handshake; valid kept high for a back-to-back item
  task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    while (!busy_mode && $urandom_range(0, 99) < 30) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {z, y, x};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CDATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(int oct, int pers, int fm, int nr);
    write_reg(CFG_OCTAVE_COUNT, CDATA_W'(oct));
    write_reg(CFG_PERSISTENCE, CDATA_W'(pers));
    write_reg(CFG_FREQ_MULT, CDATA_W'(fm));
    write_reg(CFG_NORM_RECIP, CDATA_W'(nr));
  endtask

  // random coordinate, sometimes on a lattice corner or at a field extreme
  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 24'hffffff;
      1: return {8'($urandom), 16'h0000};
      2: return {8'($urandom), 16'hffff};
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_points(int count);
    repeat (count) send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset defaults, corners, cell edges and field extremes
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'hffffff, 24'hffffff, 24'hffffff);
    send_point(24'h008000, 24'h008000, 24'h008000);
    send_point(24'h00ffff, 24'h010000, 24'hff0001);
    send_point(24'h123456, 24'hfedcba, 24'h800000);
    send_point(24'h7fffff, 24'h555555, 24'haaaaaa);
    drain();
    // zero octaves gives a flat zero
    load_setting(0, 32768, 512, 65536);
    send_point(24'h345678, 24'h9abcde, 24'h13579b);
    drain();
    // too many octaves, big reciprocal saturates, full persistence
    load_setting(15, 65535, 65535, 131071);
    send_point(24'h0c8000, 24'h214000, 24'h3f2000);
    send_point(24'hffffff, 24'h000000, 24'h800000);
    send_point(24'h008000, 24'h00c000, 24'h004000);
    drain();
    // multiplier below 256 lowers the frequency, zero persistence
    load_setting(8, 0, 100, 0);
    send_point(24'h445566, 24'h778899, 24'haabbcc);
    drain();
    load_setting(4, 0, 0, 65536);
    send_point(24'h445566, 24'h778899, 24'haabbcc);
    drain();
    // unknown register index is ignored
    cfg_we <= 1'b1; cfg_idx <= 4'hf; cfg_data <= '1;
    @(posedge clk_i);
    cfg_idx <= 4'h9; cfg_data <= '0;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    send_point(24'h010203, 24'h040506, 24'h070809);

    // back-pressure: receiver blocks while points keep coming
    busy_mode = 1'b1;
    hold_off = 1'b1;
    fork
      begin
        repeat (LATENCY * 3) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_points(LATENCY + 60);
    join
    busy_mode = 1'b0;
    drain();

    // random phases across several settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_setting(1, 32768, 512, 65536);
        1: load_setting(8, 65535, 65535, 65536);
        2: load_setting(3, 32768, 256, 131071);
        3: load_setting(2, 0, 512, 0);
        default: load_setting($urandom_range(1, 8), $urandom_range(0, 65535),
                              $urandom_range(256, 65535), $urandom_range(0, 65536));
      endcase
      busy_mode = (ph == 5);
      random_points(200);
      if (ph == 2) begin
        // sender pauses until every noise value is back
        s_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      busy_mode = 1'b0;
      drain();
    end

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gnos_pkg.sv
rtl/gnos_cell.sv
rtl/gradient_noise_3d_octave_sum.sv
test/gnos_checker.sv
test/tb_top.sv
